// ===== design/iss_pkg.sv =====
// Shared types and constants for the indexed sequence store.
package iss_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int VALUE_W      = 32;
    localparam int INDEX_W      = 6;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_DELETE     = 2'd2,
        MODE_NONE       = 2'd3
    } iss_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_LIST
    } iss_state_t;

    typedef struct packed {
        iss_mode_t                   mode;
        logic signed [VALUE_W-1:0]   item_value;
        logic        [INDEX_W-1:0]   position;
    } iss_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0]   entry_value;
        logic        [INDEX_W-1:0]   entry_index;
        logic                        last_entry;
        logic                        list_empty;
        logic                        push_dropped;
    } iss_rsp_t;

endpackage

// ===== design/indexed_sequence_store_core.sv =====
// Top level of the indexed sequence store: request decode, shift and listing control.
//
//  channel | handshake            | payload        | beats per request
//  req     | req_valid/req_stall  | iss_req_t      | 1
//  rsp     | rsp_valid/rsp_stall  | iss_rsp_t      | max(1, entries held)
//
// Entries sit in a circular buffer (head pointer plus count) in one memory.
// Pushes write the memory in the accept cycle; a delete moves each later entry down one place,
// one entry per cycle through the memory ports, then waits for the last write to land.
// Listing reads one entry per cycle while rsp is not stalled.
// Reset clears head, count and control; memory contents stay undefined.
// A stalled rsp beat holds its read data; the next request is taken once the last beat leaves.
module indexed_sequence_store_core
    import iss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  iss_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output iss_rsp_t rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    // logical position to memory address, wrapping once
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [SW-1:0] s;
        s = SW'(h) + SW'(k);
        if (s >= SW'(CAPACITY))
        begin
            s = s - SW'(CAPACITY);
        end
        return AW'(s);
    endfunction

    iss_state_t           state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 wr_vld_reg, wr_vld_next;
    logic [AW-1:0]        wr_addr_reg, wr_addr_next;
    logic                 dropped_reg, dropped_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    logic [INDEX_W-1:0]   index_reg, index_next;
    logic                 last_reg, last_next;
    logic                 empty_reg, empty_next;

    logic                 req_fire;
    logic                 advance;
    logic                 is_push;
    logic                 full;
    logic                 pos_ok;
    logic                 do_rd;
    logic                 list_go;
    logic                 list_last;
    logic                 shift_done;
    logic [AW-1:0]        head_m1;

    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [VALUE_W-1:0]   mem_wr_data;
    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    logic [VALUE_W-1:0]   mem_rd_data;

    assign advance    = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = !((state_reg == ST_IDLE) && advance);
    assign req_fire   = req_valid && !req_stall;
    assign is_push    = (req.mode == MODE_PUSH_FRONT) || (req.mode == MODE_PUSH_BACK);
    assign full       = 7'(count_reg) >= 7'(CAPACITY);
    assign pos_ok     = 7'(req.position) < 7'(count_reg);
    assign head_m1    = (head_reg == '0) ? AW'(CAPACITY - 1) : head_reg - AW'(1);
    assign do_rd      = (state_reg == ST_SHIFT) && (idx_reg <= count_reg);
    assign shift_done = (state_reg == ST_SHIFT) && !do_rd && !wr_vld_reg;
    assign list_go    = (state_reg == ST_LIST) && advance;
    assign list_last  = (count_reg == '0) || (idx_reg == count_reg - CW'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.mode == MODE_DELETE && pos_ok) ? ST_SHIFT : ST_LIST;
                end
            end
            ST_SHIFT:
            begin
                if (shift_done)
                begin
                    state_next = ST_LIST;
                end
            end
            ST_LIST:
            begin
                if (list_go && list_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        wr_vld_next    = 1'b0;
        wr_addr_next   = wr_addr_reg;
        dropped_next   = dropped_reg;
        rsp_valid_next = advance ? 1'b0 : rsp_valid_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        empty_next     = empty_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = wr_addr_reg;
        mem_wr_data    = mem_rd_data;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = phys(head_reg, idx_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    dropped_next = is_push && full;
                    idx_next     = '0;
                    mem_wr_data  = req.item_value;
                    case (req.mode)
                        MODE_PUSH_FRONT:
                        begin
                            if (!full)
                            begin
                                head_next   = head_m1;
                                count_next  = count_reg + CW'(1);
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = head_m1;
                            end
                        end
                        MODE_PUSH_BACK:
                        begin
                            if (!full)
                            begin
                                count_next  = count_reg + CW'(1);
                                mem_wr_en   = 1'b1;
                                mem_wr_addr = phys(head_reg, count_reg);
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (pos_ok)
                            begin
                                count_next = count_reg - CW'(1);
                                idx_next   = CW'(req.position) + CW'(1);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SHIFT:
            begin
                // read entry idx, write it one place down next cycle
                mem_wr_en = wr_vld_reg;
                if (do_rd)
                begin
                    mem_rd_en    = 1'b1;
                    idx_next     = idx_reg + CW'(1);
                    wr_vld_next  = 1'b1;
                    wr_addr_next = phys(head_reg, idx_reg - CW'(1));
                end
                if (shift_done)
                begin
                    idx_next = '0;
                end
            end
            ST_LIST:
            begin
                if (list_go)
                begin
                    mem_rd_en      = (count_reg != '0);
                    idx_next       = idx_reg + CW'(1);
                    rsp_valid_next = 1'b1;
                    index_next     = INDEX_W'(idx_reg);
                    last_next      = list_last;
                    empty_next     = (count_reg == '0);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            wr_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            wr_vld_reg    <= wr_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        dropped_reg <= dropped_next;
        index_reg   <= index_next;
        last_reg    <= last_next;
        empty_reg   <= empty_next;
    end

    iss_store #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (VALUE_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign rsp_valid         = rsp_valid_reg;
    assign rsp.entry_value   = empty_reg ? '0 : mem_rd_data;
    assign rsp.entry_index   = index_reg;
    assign rsp.last_entry    = last_reg;
    assign rsp.list_empty    = empty_reg;
    assign rsp.push_dropped  = dropped_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        7'(count_reg) <= 7'(CAPACITY))
        else $error("entry count above capacity");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && empty_reg |-> last_reg)
        else $error("empty beat not marked last");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !empty_reg |-> 7'(index_reg) < 7'(count_reg))
        else $error("listed index beyond entry count");

    a_shift_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en && mem_rd_en |-> mem_wr_addr != mem_rd_addr)
        else $error("read and write hit the same entry");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> state_reg != ST_IDLE && !rsp_valid_reg)
        else $error("request accepted without starting work");
`endif

endmodule

// ===== design/iss_store.sv =====
// Entry memory: one write port, one read port with registered read data.
module iss_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds while not enabled
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== bench/sequence_listing_checker.sv =====
// Checker for the indexed sequence store: own copy of the list, checks every listing beat.
`timescale 1ns / 1ps

module sequence_listing_checker
    import iss_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  iss_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  iss_rsp_t rsp,
    output int       mismatches,
    output int       beats_due
);

    logic signed [VALUE_W-1:0] held_values[$];
    iss_rsp_t                  listing_due[$];
    int                        fail_count = 0;

    // Apply one request to the list copy, then queue the full listing it produces.
    task automatic take_request(input iss_req_t r);
        logic     dropped;
        iss_rsp_t beat;
        dropped = 1'b0;
        case (r.mode) inside
            MODE_PUSH_FRONT, MODE_PUSH_BACK:
            begin
                if (held_values.size() >= CAPACITY)
                    dropped = 1'b1;
                else if (r.mode == MODE_PUSH_FRONT)
                    held_values.push_front(r.item_value);
                else
                    held_values.push_back(r.item_value);
            end
            MODE_DELETE:
            begin
                // a position at or past the end leaves the list alone
                if (r.position < held_values.size())
                    held_values.delete(r.position);
            end
            default: ;
        endcase
        if (held_values.size() == 0)
        begin
            beat = '0;
            beat.last_entry   = 1'b1;
            beat.list_empty   = 1'b1;
            beat.push_dropped = dropped;
            listing_due.push_back(beat);
        end
        else
        begin
            for (int k = 0; k < held_values.size(); k++)
            begin
                beat.entry_value  = held_values[k];
                beat.entry_index  = INDEX_W'(k);
                beat.last_entry   = (k == held_values.size() - 1);
                beat.list_empty   = 1'b0;
                beat.push_dropped = dropped;
                listing_due.push_back(beat);
            end
        end
    endtask

    task automatic check_beat(input iss_rsp_t got);
        iss_rsp_t want;
        if (listing_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("unexpected rsp beat: value %0d index %0d last %0b",
                         got.entry_value, got.entry_index, got.last_entry,
                         " empty %0b dropped %0b", got.list_empty, got.push_dropped);
        end
        else
        begin
            want = listing_due.pop_front();
            if (got.entry_value !== want.entry_value || got.entry_index !== want.entry_index
                || got.last_entry !== want.last_entry || got.list_empty !== want.list_empty
                || got.push_dropped !== want.push_dropped)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("rsp mismatch: expected value %0d index %0d last %0b empty %0b ",
                             want.entry_value, want.entry_index, want.last_entry,
                             want.list_empty,
                             "dropped %0b, got value %0d index %0d last %0b empty %0b ",
                             want.push_dropped,
                             got.entry_value, got.entry_index, got.last_entry,
                             got.list_empty,
                             "dropped %0b", got.push_dropped);
            end
        end
    endtask

    // rsp first: a beat leaving at the same edge as a request arrives belongs to the older one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_values.delete();
            listing_due.delete();
            fail_count = 0;
            mismatches <= 0;
            beats_due  <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
                check_beat(rsp);
            if (req_valid && !req_stall)
                take_request(req);
            mismatches <= fail_count;
            beats_due  <= listing_due.size();
        end
    end

endmodule

// ===== bench/indexed_sequence_store_core_test.sv =====
// Testbench top for the indexed sequence store: stimulus, rsp back-pressure and verdict.
`timescale 1ns / 1ps

module indexed_sequence_store_core_test;
    import iss_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int DRAIN_CYCLES = 140;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    iss_req_t req       = '0;
    logic     rsp_stall = 1'b0;
    logic     req_stall;
    logic     rsp_valid;
    iss_rsp_t rsp;

    int       mismatches;
    int       beats_due;
    int       cycle_count = 0;
    int       stall_left  = 0;
    bit       quiet       = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    indexed_sequence_store_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sequence_listing_checker listing_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .mismatches (mismatches),
        .beats_due  (beats_due)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // rsp back-pressure: mostly short stalls, now and then a long one, none start while quiet
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
            rsp_stall <= 1'b1;
        end
        else
            rsp_stall <= 1'b0;
    end

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (quiet || r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // holds the beat until taken; valid stays high straight into the next request when no gap
    task automatic send(input iss_mode_t m, input logic signed [VALUE_W-1:0] v,
                        input logic [INDEX_W-1:0] p);
        int gap;
        req_valid <= 1'b1;
        req       <= '{mode: m, item_value: v, position: p};
        @(posedge clk);
        while (!(req_valid && !req_stall))
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial begin
        int                        r;
        iss_mode_t                 m;
        logic signed [VALUE_W-1:0] v;
        logic [INDEX_W-1:0]        p;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, deletes on an empty list
        send(MODE_NONE, 32'h0000_0000, 6'd0);
        send(MODE_DELETE, 32'h1234_5678, 6'd0);
        send(MODE_DELETE, 32'hFFFF_FFFF, 6'd63);
        // value extremes at both ends
        send(MODE_PUSH_BACK, 32'h7FFF_FFFF, 6'd63);
        send(MODE_PUSH_FRONT, 32'h8000_0000, 6'd0);
        send(MODE_PUSH_BACK, 32'h0000_0000, 6'd42);
        send(MODE_PUSH_FRONT, 32'hFFFF_FFFF, 6'd21);
        send(MODE_PUSH_BACK, 32'h0000_0001, 6'd0);
        send(MODE_NONE, 32'hFFFF_FFFF, 6'd63);
        // out of range: exactly at the end and far past it
        send(MODE_DELETE, 32'h0000_0000, 6'd5);
        send(MODE_DELETE, 32'h0000_0000, 6'd63);
        // middle, head, tail
        send(MODE_DELETE, 32'h0000_0000, 6'd2);
        send(MODE_DELETE, 32'h0000_0000, 6'd0);
        send(MODE_DELETE, 32'h0000_0000, 6'd2);
        send(MODE_PUSH_FRONT, 32'h5555_5555, 6'd0);
        send(MODE_PUSH_BACK, 32'hAAAA_AAAA, 6'd0);
        send(MODE_DELETE, 32'h0000_0000, 6'd3);
        // drain to empty again
        repeat (4) send(MODE_DELETE, 32'h0000_0000, 6'd0);
        send(MODE_NONE, 32'h0000_0000, 6'd0);

        // phases: grow (runs into a full store), shrink, grow, mixed
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            case ((i / 100) % 4)
                0, 2:
                    if (r < 85)
                        m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
                    else if (r < 95)
                        m = MODE_DELETE;
                    else
                        m = MODE_NONE;
                1:
                    if (r < 75)
                        m = MODE_DELETE;
                    else if (r < 85)
                        m = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
                    else
                        m = MODE_NONE;
                default:
                    m = iss_mode_t'($urandom_range(0, 3));
            endcase
            v = pick_value();
            p = $urandom_range(0, 1) ? INDEX_W'($urandom_range(0, 63))
                                     : INDEX_W'($urandom_range(0, 7));
            send(m, v, p);
        end
        req_valid <= 1'b0;
        quiet = 1'b0;

        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && beats_due == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
